@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg - shared types and constants of the sorted priority queue
// Entry layout, request and status codes, sequencer states and the result
// word handed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package spq_pkg;

  // default number of entries held
  localparam int DEFAULT_CAPACITY = 16;

  // field widths of one stored entry
  localparam int RANK_W  = 4;
  localparam int LOAD_W  = 10;
  localparam int ID_W    = 10;
  localparam int ENTRY_W = RANK_W + LOAD_W + ID_W;

  // request word and result word widths
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [ENTRY_W-1:0]  entry_t;

  // request codes
  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_POP    = 2'd1;
  localparam mode_t MODE_PEEK   = 2'd2;

  // status codes
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SCAN,
    ST_KEY,
    ST_DONE
  } state_t;

  // result word from sequencer to output stage
  typedef struct packed {
    status_t              status;
    entry_t               entry;
    logic                 empty;
    logic [COUNT_W-1:0]   count;
  } result_t;

endpackage

@@ rtl/spq_ram.sv @@
// ----------------------------------------------------------------------------
// spq_ram - entry store of the sorted priority queue
// Single write port and single read port, read data registered.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int DEPTH = spq_pkg::DEFAULT_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  spq_pkg::entry_t        wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output spq_pkg::entry_t        rd_data
);

  spq_pkg::entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl - request sequencer of the sorted priority queue
// Keeps the entries as a circular sorted list in the store. Pop and peek read
// the head; insert walks from the tail towards the head, moving each larger
// entry up one place per cycle, then writes the new entry into the gap.
// ----------------------------------------------------------------------------
module spq_ctrl #(
  parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY,
  parameter int IDXW     = $clog2(CAPACITY),
  parameter int CNTW     = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request word
  input  logic                         in_valid,
  output logic                         in_stall,
  input  spq_pkg::mode_t               in_mode,
  input  logic [spq_pkg::RANK_W-1:0]   in_priority_rank,
  input  logic [spq_pkg::LOAD_W-1:0]   in_load_time,
  input  logic [spq_pkg::ID_W-1:0]     in_item_id,
  // result word to output stage
  output logic                         res_valid,
  input  logic                         res_take,
  output spq_pkg::result_t             res,
  // store port
  output logic                         wr_en,
  output logic [IDXW-1:0]              wr_addr,
  output spq_pkg::entry_t              wr_data,
  output logic                         rd_en,
  output logic [IDXW-1:0]              rd_addr,
  input  spq_pkg::entry_t              rd_data
);

  spq_pkg::state_t  st_r, st_nxt;
  logic [IDXW-1:0]  head_r, head_nxt;
  logic [IDXW-1:0]  tail_r, tail_nxt;
  logic [IDXW-1:0]  cur_r, cur_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic [CNTW-1:0]  left_r, left_nxt;
  logic             pop_r, pop_nxt;
  spq_pkg::entry_t  key_r, key_nxt;
  spq_pkg::entry_t  rent_r, rent_nxt;
  spq_pkg::status_t rstat_r, rstat_nxt;
  logic             accept;

  // circular index step forward
  function automatic logic [IDXW-1:0] idx_inc(input logic [IDXW-1:0] p);
    logic [IDXW-1:0] r;
    r = (p == IDXW'(CAPACITY - 1)) ? '0 : p + IDXW'(1);
    return r;
  endfunction

  // circular index step back
  function automatic logic [IDXW-1:0] idx_dec(input logic [IDXW-1:0] p);
    logic [IDXW-1:0] r;
    r = (p == '0) ? IDXW'(CAPACITY - 1) : p - IDXW'(1);
    return r;
  endfunction

  assign in_stall = (st_r != spq_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // result word, count taken after the update
  assign res_valid    = (st_r == spq_pkg::ST_DONE);
  assign res.status   = rstat_r;
  assign res.entry    = rent_r;
  assign res.empty    = (count_r == '0);
  assign res.count    = spq_pkg::COUNT_W'(count_r);

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= spq_pkg::ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      st_r    <= st_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    left_r  <= left_nxt;
    pop_r   <= pop_nxt;
    key_r   <= key_nxt;
    rent_r  <= rent_nxt;
    rstat_r <= rstat_nxt;
  end

  // next state and store accesses
  always_comb begin
    st_nxt    = st_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cur_nxt   = cur_r;
    count_nxt = count_r;
    left_nxt  = left_r;
    pop_nxt   = pop_r;
    key_nxt   = key_r;
    rent_nxt  = rent_r;
    rstat_nxt = rstat_r;
    wr_en     = 1'b0;
    wr_addr   = tail_r;
    wr_data   = key_r;
    rd_en     = 1'b0;
    rd_addr   = head_r;

    unique case (st_r)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          key_nxt   = {in_priority_rank, in_load_time, in_item_id};
          rent_nxt  = '0;
          rstat_nxt = spq_pkg::STATUS_OK;
          pop_nxt   = (in_mode == spq_pkg::MODE_POP);
          st_nxt    = spq_pkg::ST_DONE;
          unique case (in_mode) inside
            spq_pkg::MODE_INSERT: begin
              if (count_r == CNTW'(CAPACITY)) begin
                rstat_nxt = spq_pkg::STATUS_FULL;
              end else if (count_r == '0) begin
                // first entry goes straight in
                wr_en     = 1'b1;
                wr_addr   = tail_r;
                wr_data   = {in_priority_rank, in_load_time, in_item_id};
                tail_nxt  = idx_inc(tail_r);
                count_nxt = count_r + CNTW'(1);
              end else begin
                // start the walk at the last entry
                rd_en    = 1'b1;
                rd_addr  = idx_dec(tail_r);
                cur_nxt  = idx_dec(tail_r);
                left_nxt = count_r;
                st_nxt   = spq_pkg::ST_SCAN;
              end
            end
            spq_pkg::MODE_POP, spq_pkg::MODE_PEEK: begin
              if (count_r == '0) begin
                rstat_nxt = spq_pkg::STATUS_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = head_r;
                st_nxt  = spq_pkg::ST_HEAD;
              end
            end
            default: begin
              // unused code: no change, ok status
            end
          endcase
        end
      end
      spq_pkg::ST_HEAD: begin
        rent_nxt = rd_data;
        if (pop_r) begin
          head_nxt  = idx_inc(head_r);
          count_nxt = count_r - CNTW'(1);
        end
        st_nxt = spq_pkg::ST_DONE;
      end
      spq_pkg::ST_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = idx_inc(cur_r);
        if (rd_data > key_r) begin
          // larger entry moves up one place
          wr_data = rd_data;
          if (left_r == CNTW'(1)) begin
            st_nxt = spq_pkg::ST_KEY;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = idx_dec(cur_r);
            cur_nxt  = idx_dec(cur_r);
            left_nxt = left_r - CNTW'(1);
          end
        end else begin
          // new entry lands after the first entry not larger
          wr_data   = key_r;
          tail_nxt  = idx_inc(tail_r);
          count_nxt = count_r + CNTW'(1);
          st_nxt    = spq_pkg::ST_DONE;
        end
      end
      spq_pkg::ST_KEY: begin
        // new entry becomes the head
        wr_en     = 1'b1;
        wr_addr   = cur_r;
        wr_data   = key_r;
        tail_nxt  = idx_inc(tail_r);
        count_nxt = count_r + CNTW'(1);
        st_nxt    = spq_pkg::ST_DONE;
      end
      spq_pkg::ST_DONE: begin
        if (res_take) begin
          st_nxt = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = spq_pkg::ST_IDLE;
      end
    endcase
  end

  // occupancy never exceeds the store
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(CAPACITY))
    else $error("occupancy above capacity");

  // occupancy moves by at most one per request
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CNTW'(1) || count_r + CNTW'(1) == $past(count_r)))
    else $error("occupancy jumped");

  // no store write without a request in flight
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == spq_pkg::ST_IDLE && !in_valid) |-> !wr_en)
    else $error("store written while idle");

  // empty status only on an empty queue
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && rstat_r == spq_pkg::STATUS_EMPTY) |-> (count_r == '0))
    else $error("empty status with entries held");

  // full status only on a full queue
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && rstat_r == spq_pkg::STATUS_FULL) |-> (count_r == CNTW'(CAPACITY)))
    else $error("full status with room left");

endmodule

@@ rtl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue - sorted list priority queue for scheduler requests
// Holds up to CAPACITY entries ordered by rank, loading time and id; serves
// insert, pop smallest and peek smallest requests.
// ----------------------------------------------------------------------------
// Usage: one request word on the in_ channel (valid/stall), one result word
// on the out_ channel per request. A word moves at a clock edge with valid
// high and stall low.
// Steps: mode 3, full insert and empty pop or peek pass straight to the result
// state and then the output register; pop and peek first read the head; an
// insert into a queue of n entries walks back from the tail one entry a cycle,
// moving larger entries up through the single read and write port of the
// entry store, then writes the new entry. One request is worked on at a time.
// The output register lets a new request be accepted and worked on while the
// previous result waits; if out_stall is still high when the next result is
// ready, the sequencer holds it and in_stall stays high.
// Reset (rst_n low, synchronous) empties the queue and drops any result in
// flight; the store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [spq_pkg::MODE_W-1:0]           in_mode,
  input  logic [spq_pkg::RANK_W-1:0]           in_priority_rank,
  input  logic [spq_pkg::LOAD_W-1:0]           in_load_time,
  input  logic [spq_pkg::ID_W-1:0]             in_item_id,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [spq_pkg::STATUS_W-1:0]         out_status,
  output logic [spq_pkg::RANK_W-1:0]           out_out_priority,
  output logic [spq_pkg::LOAD_W-1:0]           out_out_load_time,
  output logic [spq_pkg::ID_W-1:0]             out_out_id,
  output logic                                 out_empty_flag,
  output logic [spq_pkg::COUNT_W-1:0]          out_entry_count
);

  localparam int IDXW = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);

  logic              wr_en;
  logic [IDXW-1:0]   wr_addr;
  spq_pkg::entry_t   wr_data;
  logic              rd_en;
  logic [IDXW-1:0]   rd_addr;
  spq_pkg::entry_t   rd_data;
  logic              res_valid;
  logic              res_take;
  spq_pkg::result_t  res;
  logic              out_valid_r, out_valid_nxt;
  spq_pkg::result_t  out_res_r;

  // request sequencer
  spq_ctrl #(
    .CAPACITY (CAPACITY),
    .IDXW     (IDXW),
    .CNTW     (CNTW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_priority_rank (in_priority_rank),
    .in_load_time     (in_load_time),
    .in_item_id       (in_item_id),
    .res_valid        (res_valid),
    .res_take         (res_take),
    .res              (res),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data)
  );

  // entry store
  spq_ram #(
    .DEPTH (CAPACITY),
    .AW    (IDXW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register takes a result when empty or being drained
  assign res_take      = res_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = res_take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  // result word fields
  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_out_priority  = out_res_r.entry[spq_pkg::ENTRY_W-1 -: spq_pkg::RANK_W];
  assign out_out_load_time = out_res_r.entry[spq_pkg::ID_W +: spq_pkg::LOAD_W];
  assign out_out_id        = out_res_r.entry[spq_pkg::ID_W-1:0];
  assign out_empty_flag    = out_res_r.empty;
  assign out_entry_count   = out_res_r.count;

endmodule
